// ===== src/dqnp_pkg.sv =====
package dqnp_pkg;

   // Fixed message layout
   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned MIN_MESSAGE_BYTES = HEADER_BYTES + 5;
   localparam int unsigned TAIL_BYTES = 4;

   // Reset value of the label limit register
   localparam logic [7:0] MAX_LABELS_RESET = 8'd128;

   // Header byte offsets
   localparam logic [15:0] OFF_ID_HI = 16'd0;
   localparam logic [15:0] OFF_ID_LO = 16'd1;
   localparam logic [15:0] OFF_COUNT_HI = 16'd4;
   localparam logic [15:0] OFF_COUNT_LO = 16'd5;
   localparam logic [15:0] OFF_HEADER_LAST = 16'(HEADER_BYTES - 1);
   localparam logic [15:0] OFF_SHORT_LIMIT = 16'(MIN_MESSAGE_BYTES - 1);

   // Parser phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_LENGTH = 3'd1;
   localparam logic [2:0] PH_LABEL = 3'd2;
   localparam logic [2:0] PH_TAIL = 3'd3;
   localparam logic [2:0] PH_SKIP = 3'd4;

   // Status and error codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT = 3'd1;
   localparam logic [2:0] ST_NO_QUESTION = 3'd2;
   localparam logic [2:0] ST_TOO_MANY_LABELS = 3'd3;
   localparam logic [2:0] ST_POINTER = 3'd4;
   localparam logic [2:0] ST_TRUNCATED = 3'd5;

   localparam logic [7:0] POINTER_MASK = 8'hC0;
   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Per-message parser state
   typedef struct packed {
      logic [15:0] position;
      logic [2:0]  phase;
      logic [7:0]  label_left;
      logic [7:0]  label_count;
      logic [15:0] id_reg;
      logic [15:0] count_reg;
      logic [2:0]  error_code;
      logic [15:0] name_end_reg;
      logic        name_started;
   } state_type;

   // One result word
   typedef struct packed {
      logic        name_valid;
      logic [7:0]  name_char;
      logic        done_res;
      logic [2:0]  status;
      logic [15:0] query_id;
      logic [15:0] name_end;
      logic [15:0] question_end;
   } result_type;

endpackage

// ===== src/dqnp_ifs.sv =====
interface dqnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface dqnp_rsp_if;
   logic        valid;
   logic        ready;
   logic        name_valid;
   logic [7:0]  name_char;
   logic        done_res;
   logic [2:0]  status;
   logic [15:0] query_id;
   logic [15:0] name_end;
   logic [15:0] question_end;
   modport source (output valid, output name_valid, output name_char, output done_res,
                   output status, output query_id, output name_end, output question_end,
                   input ready);
   modport sink (input valid, input name_valid, input name_char, input done_res,
                 input status, input query_id, input name_end, input question_end,
                 output ready);
endinterface

interface dqnp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/dqnp_step.sv =====
module dqnp_step (
   input  dqnp_pkg::state_type  cur,
   input  logic [7:0]           max_labels,
   input  logic [7:0]           data_byte,
   input  logic                 last,
   output dqnp_pkg::state_type  nxt,
   output dqnp_pkg::result_type res
);

   dqnp_pkg::state_type upd;
   logic [15:0]         pos_inc;
   logic [16:0]         q_end_sum;
   logic [2:0]          status;

   // Saturating increment of the byte offset
   assign pos_inc = (cur.position == 16'hFFFF) ? cur.position : cur.position + 16'd1;

   // Advance the parser by one byte
   always_comb begin
      upd = cur;
      res = '0;
      if (cur.error_code == dqnp_pkg::ST_OK) begin
         case (cur.phase)
            dqnp_pkg::PH_HEADER: begin
               if (cur.position == dqnp_pkg::OFF_ID_HI) begin
                  upd.id_reg[15:8] = data_byte;
               end else if (cur.position == dqnp_pkg::OFF_ID_LO) begin
                  upd.id_reg[7:0] = data_byte;
               end else if (cur.position == dqnp_pkg::OFF_COUNT_HI) begin
                  upd.count_reg[15:8] = data_byte;
               end else if (cur.position == dqnp_pkg::OFF_COUNT_LO) begin
                  upd.count_reg[7:0] = data_byte;
                  if ({cur.count_reg[15:8], data_byte} == 16'd0) begin
                     upd.error_code = dqnp_pkg::ST_NO_QUESTION;
                  end
               end
               if (cur.position >= dqnp_pkg::OFF_HEADER_LAST) begin
                  upd.phase = dqnp_pkg::PH_LENGTH;
               end
            end
            dqnp_pkg::PH_LENGTH: begin
               if (cur.label_count >= max_labels) begin
                  upd.error_code = dqnp_pkg::ST_TOO_MANY_LABELS;
               end else begin
                  upd.label_count = cur.label_count + 8'd1;
                  if (data_byte == 8'd0) begin
                     upd.name_end_reg = pos_inc;
                     upd.label_left = 8'(dqnp_pkg::TAIL_BYTES);
                     upd.phase = dqnp_pkg::PH_TAIL;
                  end else if ((data_byte & dqnp_pkg::POINTER_MASK) == dqnp_pkg::POINTER_MASK)
                  begin
                     upd.error_code = dqnp_pkg::ST_POINTER;
                  end else begin
                     upd.label_left = data_byte;
                     upd.phase = dqnp_pkg::PH_LABEL;
                     // dot between labels, never on a final length byte
                     if (cur.name_started && !last) begin
                        res.name_valid = 1'b1;
                        res.name_char = dqnp_pkg::DOT_CHAR;
                     end
                     upd.name_started = 1'b1;
                  end
               end
            end
            dqnp_pkg::PH_LABEL: begin
               res.name_valid = 1'b1;
               if (data_byte inside {[8'h41:8'h5A]}) begin
                  res.name_char = data_byte + dqnp_pkg::CASE_OFFSET;
               end else begin
                  res.name_char = data_byte;
               end
               upd.label_left = cur.label_left - 8'd1;
               if (cur.label_left == 8'd1) begin
                  upd.phase = dqnp_pkg::PH_LENGTH;
               end
            end
            dqnp_pkg::PH_TAIL: begin
               upd.label_left = cur.label_left - 8'd1;
               if (cur.label_left == 8'd1) begin
                  upd.phase = dqnp_pkg::PH_SKIP;
               end
            end
            default: begin
            end
         endcase
      end
      upd.position = pos_inc;

      // Report on the final byte and start afresh
      if (last) begin
         res.done_res = 1'b1;
         res.status = status;
         if (status == dqnp_pkg::ST_OK) begin
            res.query_id = upd.id_reg;
            res.name_end = upd.name_end_reg;
            res.question_end = q_end_sum[16] ? 16'hFFFF : q_end_sum[15:0];
         end
         nxt = '0;
         nxt.phase = dqnp_pkg::PH_HEADER;
      end else begin
         nxt = upd;
      end
   end

   assign q_end_sum = {1'b0, cur.name_end_reg} + 17'(dqnp_pkg::TAIL_BYTES);

   // Final status in check order
   always_comb begin
      if (cur.position < dqnp_pkg::OFF_SHORT_LIMIT) begin
         status = dqnp_pkg::ST_TOO_SHORT;
      end else if (upd.error_code != dqnp_pkg::ST_OK) begin
         status = upd.error_code;
      end else if (upd.phase != dqnp_pkg::PH_SKIP) begin
         status = dqnp_pkg::ST_TRUNCATED;
      end else begin
         status = dqnp_pkg::ST_OK;
      end
   end

endmodule

// ===== src/dns_query_name_parser_unit.sv =====
// DNS question-name parser.
// req_chan carries one message byte per word with a flag on the final byte.
// rsp_chan returns exactly one word per accepted byte: a lowercased name
// character or dot when name_valid is set, and on the final byte done_res
// with the status, the query id and the name and question end offsets.
// csr_chan writes the label limit (max_labels); it is always ready and
// should only be written while no message is in flight.
// The result word for a byte sits in the output register on the cycle
// after it was accepted. One byte is taken every cycle while rsp_chan
// takes each word; the per-byte state update is a single pass of logic
// between the parser state registers and the output register.
// When rsp_chan stalls, the output register holds its word and req_chan
// ready drops until the word is taken; a word taken in the same cycle frees
// the register for the next byte.
// Reset clears the parser state to the start of a message, empties the
// output register and sets max_labels to 128.
module dns_query_name_parser_unit (
   input logic       clock,
   input logic       reset,
   dqnp_req_if.sink  req_chan,
   dqnp_rsp_if.source rsp_chan,
   dqnp_csr_if.sink  csr_chan
);

   dqnp_pkg::state_type  state_ff;
   dqnp_pkg::state_type  state_in;
   dqnp_pkg::result_type result_ff;
   dqnp_pkg::result_type result_in;
   logic                 rsp_valid_ff;
   logic [7:0]           max_labels_ff;
   logic                 req_accept;

   // Take a byte whenever the output register is free or being emptied
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   dqnp_step u_step (
      .cur        (state_ff),
      .max_labels (max_labels_ff),
      .data_byte  (req_chan.data_byte),
      .last       (req_chan.last),
      .nxt        (state_in),
      .res        (result_in)
   );

   // Label limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_labels_ff <= dqnp_pkg::MAX_LABELS_RESET;
      end else if (csr_chan.valid) begin
         max_labels_ff <= csr_chan.data;
      end
   end

   // Advance parser state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: dqnp_pkg::PH_HEADER, default: '0};
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Output register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.name_valid = result_ff.name_valid;
   assign rsp_chan.name_char = result_ff.name_char;
   assign rsp_chan.done_res = result_ff.done_res;
   assign rsp_chan.status = result_ff.status;
   assign rsp_chan.query_id = result_ff.query_id;
   assign rsp_chan.name_end = result_ff.name_end;
   assign rsp_chan.question_end = result_ff.question_end;

`ifndef ASSERT_OFF
   // A final byte returns the parser to the start of a message
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.last |=> state_ff.position == 16'd0 &&
      state_ff.error_code == dqnp_pkg::ST_OK)
      else $error("parser state not cleared after final byte");

   // The first error sticks for the rest of the message
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_chan.last && state_ff.error_code != dqnp_pkg::ST_OK |=>
      state_ff.error_code == $past(state_ff.error_code))
      else $error("error code changed within a message");

   // Position never moves back within a message
   a_position_mono: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_chan.last |=> state_ff.position >= $past(state_ff.position))
      else $error("position moved backwards");

   // Failed or unfinished messages report no id or offsets
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status != dqnp_pkg::ST_OK |->
      result_ff.query_id == 16'd0 && result_ff.name_end == 16'd0 &&
      result_ff.question_end == 16'd0)
      else $error("id or offsets reported with a failing status");

   // Status is only given on the final word of a message
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.done_res |-> result_ff.status == dqnp_pkg::ST_OK)
      else $error("status reported before the final byte");
`endif

endmodule
